[rtl/core/ccc_pkg.sv]
// ----------------------------------------------------------------------------
// ccc_pkg: shared types and constants of the cylinder clearance check unit
// Payload structs, register indexes, pipeline schedule and arithmetic helpers.
// ----------------------------------------------------------------------------
package ccc_pkg;

   // Q1.14 unit gradient
   localparam logic signed [15:0] GRAD_ONE = 16'sd16384;

   // Register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_CENTER_X     = 3'd0;
   localparam logic [2:0] REG_CENTER_Y     = 3'd1;
   localparam logic [2:0] REG_CYL_RADIUS   = 3'd2;
   localparam logic [2:0] REG_Z_BOTTOM     = 3'd3;
   localparam logic [2:0] REG_Z_TOP        = 3'd4;
   localparam logic [2:0] REG_MARGIN       = 3'd5;
   localparam logic [2:0] REG_ACT_DIST     = 3'd6;
   localparam logic [2:0] REG_CHECK_ENABLE = 3'd7;

   // Pipeline schedule
   localparam int SQRT_STEPS  = 25;   // one root bit per stage, 50-bit radicand
   localparam int DIV_STEPS   = 15;   // one quotient bit per stage, q <= 16384
   localparam int ST_ENTRY    = 0;
   localparam int ST_SQ1      = 1;
   localparam int ST_SUM1     = 2;
   localparam int ST_ROOT1    = 3;
   localparam int ST_DIV1_SET = ST_ROOT1 + SQRT_STEPS;
   localparam int ST_DIV1     = ST_DIV1_SET + 1;
   localparam int ST_RADIAL   = ST_DIV1 + DIV_STEPS;
   localparam int ST_SQ2      = ST_RADIAL + 1;
   localparam int ST_SUM2     = ST_SQ2 + 1;
   localparam int ST_ROOT2    = ST_SUM2 + 1;
   localparam int ST_DIV2_SET = ST_ROOT2 + SQRT_STEPS;
   localparam int ST_DIV2     = ST_DIV2_SET + 1;
   localparam int ST_SCALE    = ST_DIV2 + DIV_STEPS;
   localparam int ST_GRAD     = ST_SCALE + 1;
   localparam int ST_CLEAR    = ST_GRAD + 1;
   localparam int NUM_STAGES  = ST_CLEAR + 1;

   typedef struct packed {
      logic signed [23:0] point_x;
      logic signed [23:0] point_y;
      logic signed [23:0] point_z;
      logic        [22:0] sphere_radius;
      logic               exempt_in;
   } req_type;

   typedef struct packed {
      logic signed [23:0] center_distance;
      logic signed [23:0] clearance;
      logic signed [15:0] grad_x;
      logic signed [15:0] grad_y;
      logic signed [15:0] grad_z;
      logic               active;
      logic               exempt_out;
   } rsp_type;

   // Digit-by-digit square root state
   typedef struct packed {
      logic [49:0] n;
      logic [26:0] rem;
      logic [24:0] root;
   } sqrt_type;

   // Everything one point carries down the pipeline
   typedef struct packed {
      logic signed [24:0] dx;
      logic signed [24:0] dy;
      logic signed [24:0] below;
      logic signed [24:0] above;
      logic        [22:0] srad;
      logic               exempt;
      logic        [49:0] m0;
      logic        [49:0] m1;
      sqrt_type           sq;
      logic        [24:0] rd;
      logic        [41:0] rem_a;
      logic        [41:0] rem_b;
      logic        [25:0] d2;
      logic        [14:0] q_a;
      logic        [14:0] q_b;
      logic               neg_a;
      logic               neg_b;
      logic signed [15:0] rgx;
      logic signed [15:0] rgy;
      logic signed [25:0] rs;
      logic signed [24:0] vs;
      logic               corner;
      logic               vneg;
      logic        [24:0] dc;
      logic signed [31:0] pgx;
      logic signed [31:0] pgy;
      logic signed [15:0] gx;
      logic signed [15:0] gy;
      logic signed [15:0] gz;
      logic signed [26:0] sdist;
      rsp_type            rsp;
   } work_type;

   // One root bit: bring down two radicand bits, try (4*root + 1)
   function automatic sqrt_type sqrt_step(sqrt_type x);
      logic [28:0] trem;
      logic [28:0] trial;
      sqrt_type    y;
      trem  = {x.rem, x.n[49:48]};
      trial = {2'b00, x.root, 2'b01};
      y.n   = {x.n[47:0], 2'b00};
      if (trem >= trial) begin
         y.rem  = 27'(trem - trial);
         y.root = {x.root[23:0], 1'b1};
      end else begin
         y.rem  = trem[26:0];
         y.root = {x.root[23:0], 1'b0};
      end
      return y;
   endfunction

   // Clamp to the 24-bit signed range
   function automatic logic signed [23:0] sat24(logic signed [27:0] v);
      if (v > 28'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (v < -28'sd8388608) begin
         return 24'sh800000;
      end
      return v[23:0];
   endfunction

   // Q1.14 product back to Q1.14, halves away from zero
   function automatic logic signed [15:0] round_q14(logic signed [31:0] p);
      logic [31:0] mag;
      logic [31:0] r;
      mag = p[31] ? 32'(-p) : 32'(p);
      r   = (mag + 32'd8192) >> 14;
      return p[31] ? -16'(r[15:0]) : 16'(r[15:0]);
   endfunction

endpackage

[rtl/core/cylinder_clearance_check_unit.sv]
// ----------------------------------------------------------------------------
// cylinder_clearance_check_unit: link sphere clearance to a finite cylinder
// Signed distance, unit gradient, clearance and active flag for one point.
// ----------------------------------------------------------------------------
// One point is accepted per clock cycle while req_ready is high, and one result
// leaves per cycle while rsp_ready is high. Each point passes 91 pipeline
// registers, the first loaded at the req transfer, and then the output register.
// The depth is set by two 25-stage square-root units (radial distance and corner
// hypotenuse) and two 15-stage restoring divider pairs (radial normal and corner
// blend weights), one bit per stage. A one-entry skid stage behind the output
// register lets one more point enter while a result waits; req_ready drops only
// when both are full. The user must write the registers over the APB port only
// while no point is in flight; the block itself does not enforce this.
module cylinder_clearance_check_unit
   import ccc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // ---------------------------------------------------------------- CSRs
   logic signed [23:0] center_x_ff, center_y_ff, z_bottom_ff, z_top_ff;
   logic signed [23:0] margin_ff, act_dist_ff;
   logic        [22:0] cyl_radius_ff;
   logic               check_enable_ff;
   logic               csr_write;
   logic        [2:0]  csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         cyl_radius_ff   <= '0;
         z_bottom_ff     <= '0;
         z_top_ff        <= '0;
         margin_ff       <= '0;
         act_dist_ff     <= '0;
         check_enable_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_CENTER_X:     center_x_ff     <= pwdata[23:0];
            REG_CENTER_Y:     center_y_ff     <= pwdata[23:0];
            REG_CYL_RADIUS:   cyl_radius_ff   <= pwdata[22:0];
            REG_Z_BOTTOM:     z_bottom_ff     <= pwdata[23:0];
            REG_Z_TOP:        z_top_ff        <= pwdata[23:0];
            REG_MARGIN:       margin_ff       <= pwdata[23:0];
            REG_ACT_DIST:     act_dist_ff     <= pwdata[23:0];
            REG_CHECK_ENABLE: check_enable_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (csr_index)
         REG_CENTER_X:     prdata = {8'h00, center_x_ff};
         REG_CENTER_Y:     prdata = {8'h00, center_y_ff};
         REG_CYL_RADIUS:   prdata = {9'h000, cyl_radius_ff};
         REG_Z_BOTTOM:     prdata = {8'h00, z_bottom_ff};
         REG_Z_TOP:        prdata = {8'h00, z_top_ff};
         REG_MARGIN:       prdata = {8'h00, margin_ff};
         REG_ACT_DIST:     prdata = {8'h00, act_dist_ff};
         REG_CHECK_ENABLE: prdata = {31'h0, check_enable_ff};
         default:          prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- pipeline
   logic [NUM_STAGES-1:0] vld_ff;
   work_type              work_ff [NUM_STAGES];
   work_type              work_in [NUM_STAGES];
   logic                  adv;
   logic                  out_vld_ff, skid_vld_ff;
   rsp_type               out_data_ff, skid_data_ff;
   logic                  rsp_take;

   assign adv       = !skid_vld_ff;
   assign req_ready = adv;
   assign rsp_take  = out_vld_ff && rsp_ready;

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      if (s == ST_ENTRY) begin : g_entry
         // offsets from the axis and the two caps
         always_comb begin
            work_type w;
            w        = 'x;
            w.dx     = 25'(req_data.point_x) - 25'(center_x_ff);
            w.dy     = 25'(req_data.point_y) - 25'(center_y_ff);
            w.below  = 25'(z_bottom_ff) - 25'(req_data.point_z);
            w.above  = 25'(req_data.point_z) - 25'(z_top_ff);
            w.srad   = req_data.sphere_radius;
            w.exempt = req_data.exempt_in;
            work_in[s] = w;
         end
      end else if (s == ST_SQ1) begin : g_sq1
         always_comb begin
            work_type           w;
            logic signed [24:0] a, b;
            logic signed [49:0] pa, pb;
            w  = work_ff[s-1];
            a  = w.dx;
            b  = w.dy;
            pa = a * a;
            pb = b * b;
            w.m0 = pa;
            w.m1 = pb;
            work_in[s] = w;
         end
      end else if (s == ST_SQ2) begin : g_sq2
         // squares of the radial and vertical excesses
         always_comb begin
            work_type           w;
            logic signed [25:0] a;
            logic signed [24:0] b;
            logic signed [51:0] pa;
            logic signed [49:0] pb;
            w  = work_ff[s-1];
            a  = w.rs;
            b  = w.vs;
            pa = a * a;
            pb = b * b;
            w.m0 = pa[49:0];
            w.m1 = pb;
            work_in[s] = w;
         end
      end else if (s == ST_SUM1 || s == ST_SUM2) begin : g_sum
         always_comb begin
            work_type w;
            w         = work_ff[s-1];
            w.sq.n    = w.m0 + w.m1;
            w.sq.rem  = '0;
            w.sq.root = '0;
            work_in[s] = w;
         end
      end else if ((s >= ST_ROOT1 && s < ST_DIV1_SET) ||
                   (s >= ST_ROOT2 && s < ST_DIV2_SET)) begin : g_root
         always_comb begin
            work_type w;
            w    = work_ff[s-1];
            w.sq = sqrt_step(w.sq);
            work_in[s] = w;
         end
      end else if (s == ST_DIV1_SET) begin : g_div1_set
         // numerators 2*|d|*16384 + rd for rounding, divisor 2*rd
         always_comb begin
            work_type    w;
            logic [24:0] ua, ub;
            w       = work_ff[s-1];
            w.rd    = w.sq.root;
            w.neg_a = w.dx[24];
            w.neg_b = w.dy[24];
            ua      = w.dx[24] ? 25'(-w.dx) : 25'(w.dx);
            ub      = w.dy[24] ? 25'(-w.dy) : 25'(w.dy);
            w.rem_a = 42'({ua, 15'b0}) + 42'(w.rd);
            w.rem_b = 42'({ub, 15'b0}) + 42'(w.rd);
            w.d2    = {w.rd, 1'b0};
            w.q_a   = '0;
            w.q_b   = '0;
            work_in[s] = w;
         end
      end else if (s == ST_DIV2_SET) begin : g_div2_set
         // blend weights rs/d and vs/d (meaningful in the exterior corner)
         always_comb begin
            work_type w;
            w       = work_ff[s-1];
            w.dc    = w.sq.root;
            w.rem_a = 42'({w.rs[24:0], 15'b0}) + 42'(w.dc);
            w.rem_b = 42'({w.vs[23:0], 15'b0}) + 42'(w.dc);
            w.d2    = {w.dc, 1'b0};
            w.q_a   = '0;
            w.q_b   = '0;
            work_in[s] = w;
         end
      end else if ((s >= ST_DIV1 && s < ST_RADIAL) ||
                   (s >= ST_DIV2 && s < ST_SCALE)) begin : g_div
         localparam int BIT = (s < ST_RADIAL) ? (DIV_STEPS - 1 - (s - ST_DIV1))
                                               : (DIV_STEPS - 1 - (s - ST_DIV2));
         // one restoring quotient bit for both dividers
         always_comb begin
            work_type    w;
            logic [41:0] sd;
            w  = work_ff[s-1];
            sd = 42'(w.d2) << BIT;
            if (w.rem_a >= sd) begin
               w.rem_a  = w.rem_a - sd;
               w.q_a[BIT] = 1'b1;
            end
            if (w.rem_b >= sd) begin
               w.rem_b  = w.rem_b - sd;
               w.q_b[BIT] = 1'b1;
            end
            work_in[s] = w;
         end
      end else if (s == ST_RADIAL) begin : g_radial
         // radial normal, excesses, region decode
         always_comb begin
            work_type           w;
            logic signed [15:0] qa, qb;
            w  = work_ff[s-1];
            qa = {1'b0, w.q_a};
            qb = {1'b0, w.q_b};
            if (w.rd == '0) begin
               w.rgx = GRAD_ONE;
               w.rgy = '0;
            end else begin
               w.rgx = w.neg_a ? -qa : qa;
               w.rgy = w.neg_b ? -qb : qb;
            end
            w.rs     = $signed({1'b0, w.rd}) - $signed({3'b000, cyl_radius_ff});
            w.vs     = (w.below > w.above) ? w.below : w.above;
            w.vneg   = (w.below >= w.above);
            w.corner = !w.rs[25] && (w.rs != '0) && !w.vs[24] && (w.vs != '0);
            work_in[s] = w;
         end
      end else if (s == ST_SCALE) begin : g_scale
         always_comb begin
            work_type           w;
            logic signed [15:0] kr;
            w     = work_ff[s-1];
            kr    = {1'b0, w.q_a};
            w.pgx = w.rgx * kr;
            w.pgy = w.rgy * kr;
            work_in[s] = w;
         end
      end else if (s == ST_GRAD) begin : g_grad
         // region select of distance and gradient
         always_comb begin
            work_type           w;
            logic signed [26:0] rs27, vs27;
            logic signed [15:0] kv;
            w    = work_ff[s-1];
            rs27 = {w.rs[25], w.rs};
            vs27 = {{2{w.vs[24]}}, w.vs};
            kv   = {1'b0, w.q_b};
            if (w.corner) begin
               w.sdist = {2'b00, w.dc};
               w.gx    = round_q14(w.pgx);
               w.gy    = round_q14(w.pgy);
               w.gz    = w.vneg ? -kv : kv;
            end else if (rs27 >= vs27) begin
               w.sdist = rs27;
               w.gx    = w.rgx;
               w.gy    = w.rgy;
               w.gz    = '0;
            end else begin
               w.sdist = vs27;
               w.gx    = '0;
               w.gy    = '0;
               w.gz    = w.vneg ? -GRAD_ONE : GRAD_ONE;
            end
            work_in[s] = w;
         end
      end else begin : g_clear
         // clearance, saturation and activation
         always_comb begin
            work_type           w;
            logic signed [27:0] d28, clr, act28;
            w     = work_ff[s-1];
            d28   = {w.sdist[26], w.sdist};
            clr   = d28 - $signed({5'b00000, w.srad})
                        - $signed({{4{margin_ff[23]}}, margin_ff});
            act28 = {{4{act_dist_ff[23]}}, act_dist_ff};
            w.rsp.center_distance  = sat24(d28);
            w.rsp.clearance        = sat24(clr);
            w.rsp.grad_x           = w.gx;
            w.rsp.grad_y           = w.gy;
            w.rsp.grad_z           = w.gz;
            w.rsp.active           = check_enable_ff && !w.exempt && (clr <= act28);
            w.rsp.exempt_out       = w.exempt;
            work_in[s] = w;
         end
      end
   end

   // stage registers: valid bits reset, payload does not
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NUM_STAGES-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         work_ff <= work_in;
      end
   end

   // ---------------------------------------------------------------- output
   // output register plus one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_take) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (!out_vld_ff || rsp_take) begin
         out_vld_ff <= vld_ff[NUM_STAGES-1];
      end else if (vld_ff[NUM_STAGES-1]) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (rsp_take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (!out_vld_ff || rsp_take) begin
         out_data_ff <= work_ff[NUM_STAGES-1].rsp;
      end else begin
         skid_data_ff <= work_ff[NUM_STAGES-1].rsp;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   // ---------------------------------------------------------------- checks
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry held without an output result");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && !rsp_ready) |=> skid_vld_ff)
      else $error("skid entry lost while output stalled");

   a_grad_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_data.grad_x) <= GRAD_ONE &&
                     $signed(rsp_data.grad_x) >= -GRAD_ONE &&
                     $signed(rsp_data.grad_z) <= GRAD_ONE &&
                     $signed(rsp_data.grad_z) >= -GRAD_ONE))
      else $error("gradient component beyond unit range");

   a_exempt_inactive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.exempt_out) |-> !rsp_data.active)
      else $error("exempt sphere flagged active");

endmodule

[sim/cylinder_clearance_check_unit_tb.sv]
// ----------------------------------------------------------------------------
// cylinder_clearance_check_unit_tb: self-checking bench for the clearance unit
// Drives points over the req channel, predicts distance, gradient, clearance
// and active flag for each, and compares every rsp transfer in order. Runs
// several register settings and idling phases, with one long rsp hold-off.
// ----------------------------------------------------------------------------
module cylinder_clearance_check_unit_tb;
   import ccc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_LATENCY = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Shadow register set used by the predictor
   logic signed [23:0] sh_cx, sh_cy, sh_zb, sh_zt, sh_margin, sh_act;
   logic        [22:0] sh_rad;
   logic               sh_en;

   req_type point_queue[$];
   rsp_type clearance_queue[$];
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      hold_off_cycles = 0;
   bit      failed = 1'b0;

   cylinder_clearance_check_unit u_dut (.*);

   always #5 clock = ~clock;

   // Integer square root, floor
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Divide rounding to nearest, halves away from zero; den > 0
   function automatic longint round_div(longint num, longint den);
      longint unsigned mag;
      longint unsigned q;
      mag = num < 0 ? -num : num;
      q = (2 * mag + den) / (2 * den);
      return num < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   // Signed distance, gradient and clearance of one point
   function automatic rsp_type predict_clearance(req_type p);
      longint dx, dy, rd, rgx, rgy, rs, below, above, vs, vsign;
      longint d, gx, gy, gz, kr, kv, clr;
      rsp_type r;
      dx = longint'(p.point_x) - longint'(sh_cx);
      dy = longint'(p.point_y) - longint'(sh_cy);
      rd = int_sqrt(dx * dx + dy * dy);
      rgx = 16384;
      rgy = 0;
      if (rd > 0) begin
         rgx = round_div(dx * 16384, rd);
         rgy = round_div(dy * 16384, rd);
      end
      rs = rd - longint'(sh_rad);
      below = longint'(sh_zb) - longint'(p.point_z);
      above = longint'(p.point_z) - longint'(sh_zt);
      vs = below > above ? below : above;
      vsign = below >= above ? -1 : 1;
      if (rs > 0 && vs > 0) begin
         // exterior corner: hypotenuse and blended normal
         d = int_sqrt(rs * rs + vs * vs);
         kr = round_div(rs * 16384, d);
         kv = round_div(vs * 16384, d);
         gx = round_div(rgx * kr, 16384);
         gy = round_div(rgy * kr, 16384);
         gz = vsign * kv;
      end else if (rs >= vs) begin
         d = rs; gx = rgx; gy = rgy; gz = 0;
      end else begin
         d = vs; gx = 0; gy = 0; gz = vsign * 16384;
      end
      clr = d - longint'(p.sphere_radius) - longint'(sh_margin);
      r.center_distance  = 24'(clamp24(d));
      r.clearance        = 24'(clamp24(clr));
      r.grad_x = 16'(gx);
      r.grad_y = 16'(gy);
      r.grad_z = 16'(gz);
      r.active = sh_en && !p.exempt_in && clr <= longint'(sh_act);
      r.exempt_out = p.exempt_in;
      return r;
   endfunction

   // Driver: offers queued points, predicts on each transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            clearance_queue.push_back(predict_clearance(req_data));
         end
         if (!req_valid || req_ready) begin
            if (point_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= point_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each rsp transfer with the oldest expectation
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (clearance_queue.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               failed = 1'b1;
            end else begin
               exp_r = clearance_queue.pop_front();
               if (exp_r !== rsp_data) begin
                  $display("%0t: mismatch expected %h actual %h", $time, exp_r, rsp_data);
                  $display("   dist %0d/%0d clr %0d/%0d g %0d,%0d,%0d / %0d,%0d,%0d",
                           exp_r.center_distance, rsp_data.center_distance,
                           exp_r.clearance, rsp_data.clearance,
                           exp_r.grad_x, exp_r.grad_y, exp_r.grad_z,
                           rsp_data.grad_x, rsp_data.grad_y, rsp_data.grad_z);
                  $display("   active %b/%b exempt %b/%b", exp_r.active, rsp_data.active,
                           exp_r.exempt_out, rsp_data.exempt_out);
                  failed = 1'b1;
               end
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= $urandom_range(99) >= recv_stall_pct;
         end
      end
   end

   // Register write: setup then access cycle; shadow updated alongside
   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_CENTER_X:     sh_cx = val[23:0];
         REG_CENTER_Y:     sh_cy = val[23:0];
         REG_CYL_RADIUS:   sh_rad = val[22:0];
         REG_Z_BOTTOM:     sh_zb = val[23:0];
         REG_Z_TOP:        sh_zt = val[23:0];
         REG_MARGIN:       sh_margin = val[23:0];
         REG_ACT_DIST:     sh_act = val[23:0];
         REG_CHECK_ENABLE: sh_en = val[0];
         default: ;
      endcase
   endtask

   task automatic write_geometry(int cx, int cy, int rad, int zb, int zt, int mg, int act,
                                 bit en);
      csr_write(REG_CENTER_X, 32'(cx));
      csr_write(REG_CENTER_Y, 32'(cy));
      csr_write(REG_CYL_RADIUS, 32'(rad));
      csr_write(REG_Z_BOTTOM, 32'(zb));
      csr_write(REG_Z_TOP, 32'(zt));
      csr_write(REG_MARGIN, 32'(mg));
      csr_write(REG_ACT_DIST, 32'(act));
      csr_write(REG_CHECK_ENABLE, 32'(en));
   endtask

   // Wait until every queued point has gone through and its result arrived
   task automatic drain();
      while (point_queue.size() > 0 || req_valid || clearance_queue.size() > 0)
         @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   function automatic req_type make_point(int x, int y, int z, int r, bit ex);
      req_type p;
      p.point_x = 24'(x); p.point_y = 24'(y); p.point_z = 24'(z);
      p.sphere_radius = 23'(r); p.exempt_in = ex;
      return p;
   endfunction

   // Random point: mostly near the cylinder, sometimes full range
   function automatic req_type rand_point(int span);
      req_type p;
      if ($urandom_range(9) < 2) begin
         p = req_type'({$urandom, $urandom, $urandom});
      end else begin
         p.point_x = 24'(int'(sh_cx) + $signed($urandom_range(2 * span)) - span);
         p.point_y = 24'(int'(sh_cy) + $signed($urandom_range(2 * span)) - span);
         p.point_z = 24'(int'(sh_zb) + $signed($urandom_range(2 * span)) - span / 2);
         p.sphere_radius = 23'($urandom_range(span / 4));
         p.exempt_in = $urandom_range(3) == 0;
      end
      return p;
   endfunction

   initial begin
      sh_cx = 0; sh_cy = 0; sh_rad = 0; sh_zb = 0; sh_zt = 0;
      sh_margin = 0; sh_act = 0; sh_en = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset registers, then extremes, axis, corners, inverted caps
      point_queue.push_back(make_point(0, 0, 0, 0, 0));
      point_queue.push_back(make_point(100, -200, 50, 3, 1));
      drain();
      write_geometry(65536, -32768, 32768, -65536, 131072, 4096, 0, 1);
      point_queue.push_back(make_point(65536, -32768, 0, 0, 0));          // on axis
      point_queue.push_back(make_point(65536, -32768, 500000, 100, 0));   // axis, above
      point_queue.push_back(make_point(200000, 100000, 300000, 10, 0));   // corner above
      point_queue.push_back(make_point(-200000, 0, -300000, 10, 0));      // corner below
      point_queue.push_back(make_point(65536 + 32768, -32768, 0, 0, 0));  // on the surface
      point_queue.push_back(make_point(65536 + 1000, -32768 + 1000, 30000, 0, 1));
      point_queue.push_back(make_point(8388607, 8388607, 8388607, 8388607, 0));
      point_queue.push_back(make_point(-8388608, -8388608, -8388608, 0, 1));
      point_queue.push_back(make_point(8388607, -8388608, -8388608, 8388607, 0));
      point_queue.push_back(make_point(-8388608, 8388607, 8388607, 1, 0));
      point_queue.push_back(make_point(65536, 100000, 32768, 0, 0));     // tie region
      drain();
      write_geometry(-8388608, 8388607, 8388607, 8388607, -8388608, -8388608, 8388607, 1);
      point_queue.push_back(make_point(8388607, -8388608, 0, 0, 0));
      point_queue.push_back(make_point(0, 0, 0, 8388607, 0));
      point_queue.push_back(make_point(-8388608, 8388607, 8388607, 0, 0));
      point_queue.push_back(make_point(-8388608, 8388607, -8388608, 0, 1));
      drain();
      write_geometry(8388607, -8388608, 0, 1000, 1000, 8388607, -8388608, 0);
      point_queue.push_back(make_point(8388607, -8388608, 1000, 0, 0));
      point_queue.push_back(make_point(-8388608, 8388607, -8388608, 8388607, 0));
      point_queue.push_back(make_point(0, 0, 0, 5, 0));
      drain();
      // Single write of the enable ahead of the random phases
      csr_write(REG_CHECK_ENABLE, 32'h1);

      // Random phases with different idling and register settings
      for (int ph = 0; ph < 7; ph++) begin
         int span;
         span = (ph % 2) ? 200000 : 3000;
         write_geometry($signed($urandom_range(400000)) - 200000,
                        $signed($urandom_range(400000)) - 200000,
                        $urandom_range(span),
                        $signed($urandom_range(span)) - span / 2,
                        (ph == 5) ? -span : $urandom_range(span),
                        $signed($urandom_range(span / 4)) - span / 8,
                        $signed($urandom_range(span / 4)) - span / 8,
                        ph != 3);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         if (ph == 4) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            hold_off_cycles = 400;
         end
         for (int i = 0; i < 100; i++) point_queue.push_back(rand_point(span));
         drain();
      end

      if (!failed) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[files.f]
rtl/core/ccc_pkg.sv
rtl/core/cylinder_clearance_check_unit.sv
sim/cylinder_clearance_check_unit_tb.sv
